// File: hdl/blp_pkg.sv
// ============================================================================
// blp_pkg
// Shared types, request codes, status codes and error codes for the buffer
// descriptor pool.
// ============================================================================
`default_nettype none

package blp_pkg;

    // Defaults for the top-level parameters.
    localparam int ENTRY_COUNT_DEF = 4;
    localparam int MAX_BYTES_DEF   = 8192;

    // Largest value the recorded size field can hold.
    localparam int SIZE_FIELD_MAX = 16383;

    typedef logic [2:0] req_t;
    typedef logic [1:0] status_t;
    typedef logic [1:0] err_t;

    localparam req_t REQ_ALLOCATE     = 3'd0;
    localparam req_t REQ_MARK_WRITTEN = 3'd1;
    localparam req_t REQ_MARK_XFERRED = 3'd2;
    localparam req_t REQ_RELEASE      = 3'd3;
    localparam req_t REQ_RESET_ALL    = 3'd4;
    localparam req_t REQ_QUERY        = 3'd5;

    localparam status_t ST_FREE        = 2'd0;
    localparam status_t ST_BUSY        = 2'd1;
    localparam status_t ST_WRITTEN     = 2'd2;
    localparam status_t ST_TRANSFERRED = 2'd3;

    localparam err_t ERR_OK      = 2'd0;
    localparam err_t ERR_BOUNDS  = 2'd1;
    localparam err_t ERR_STATUS  = 2'd2;
    localparam err_t ERR_NO_FREE = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the incoming request
        logic commit;    // apply the request and load the result register
    } cmd_t;

endpackage

`default_nettype wire

// File: hdl/buffer_lifecycle_pool.sv
// ============================================================================
// buffer_lifecycle_pool
// Pool of buffer descriptors with a free/busy/written/transferred life cycle,
// a recorded size per entry, and a summary of free and written entries.
// ============================================================================
//
//  Channel   Handshake                Payload
//  --------  -----------------------  ----------------------------------------
//  request   req_valid / req_ready    req_type, entry_index, request_size
//  response  rsp_valid / rsp_ready    error_code, granted_index, entry_status,
//                                     entry_size, can_allocate, written_found,
//                                     written_index
//
//  A transaction first registers the request; once the output register is free
//  it checks it, updates the tables and searches for the lowest free and
//  written entries, which is the single path that sets the cycle.
//  The next request is taken while the previous response still waits in its
//  output register; a request then holds until that register is emptied.
//  Reset clears all entries to free with size zero directly; no clearing
//  pass is needed.
//
`default_nettype none

module buffer_lifecycle_pool
#(
    parameter int ENTRY_COUNT = blp_pkg::ENTRY_COUNT_DEF,
    parameter int MAX_BYTES   = blp_pkg::MAX_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Request channel.
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [2:0]  req_type,
    input  wire logic [7:0]  entry_index,
    input  wire logic [15:0] request_size,

    // Response channel.
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [1:0]       error_code,
    output logic [7:0]       granted_index,
    output logic [1:0]       entry_status,
    output logic [13:0]      entry_size,
    output logic             can_allocate,
    output logic             written_found,
    output logic [7:0]       written_index
);
    import blp_pkg::*;

    // Commands from the sequencer: capture latches an accepted request, and
    // commit applies it to the tables and loads the response register.
    cmd_t cmd;

    blp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    // The datapath holds the status and size of every descriptor. Failed
    // requests leave both tables untouched and only report an error code.
    blp_datapath
    #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .MAX_BYTES   (MAX_BYTES)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .req_type      (req_type),
        .entry_index   (entry_index),
        .request_size  (request_size),
        .error_code    (error_code),
        .granted_index (granted_index),
        .entry_status  (entry_status),
        .entry_size    (entry_size),
        .can_allocate  (can_allocate),
        .written_found (written_found),
        .written_index (written_index)
    );

endmodule

`default_nettype wire

// File: hdl/blp_ctrl.sv
// ============================================================================
// blp_ctrl
// Sequencer for the descriptor pool: takes a request, then commits it once
// the result register is free.
// ============================================================================
`default_nettype none

module blp_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output blp_pkg::cmd_t      cmd
);
    import blp_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd.capture = req_valid && (state_reg == S_IDLE);
        cmd.commit  = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);

        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // A committed request always presents a result on the next cycle.
    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp_valid_reg)
        else $error("commit did not raise the result valid");

    // A pending request waits while the previous result is still held.
    a_exec_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && rsp_valid_reg && !rsp_ready |=> (state_reg == S_EXEC))
        else $error("request left execution while the result register was full");

    // After a request is taken, no further request is taken until it commits.
    a_capture_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !req_ready)
        else $error("ready stayed high after a request was taken");

endmodule

`default_nettype wire

// File: hdl/blp_datapath.sv
// ============================================================================
// blp_datapath
// Descriptor status and size tables, request register, transition checks,
// lowest-entry searches and the result register.
// ============================================================================
`default_nettype none

module blp_datapath
#(
    parameter int ENTRY_COUNT = blp_pkg::ENTRY_COUNT_DEF,
    parameter int MAX_BYTES   = blp_pkg::MAX_BYTES_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire blp_pkg::cmd_t  cmd,
    input  wire logic [2:0]     req_type,
    input  wire logic [7:0]     entry_index,
    input  wire logic [15:0]    request_size,
    output logic [1:0]          error_code,
    output logic [7:0]          granted_index,
    output logic [1:0]          entry_status,
    output logic [13:0]         entry_size,
    output logic                can_allocate,
    output logic                written_found,
    output logic [7:0]          written_index
);
    import blp_pkg::*;

    localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam logic [15:0] SIZE_LIMIT =
        (MAX_BYTES > SIZE_FIELD_MAX) ? 16'(SIZE_FIELD_MAX) : 16'(MAX_BYTES);
    localparam logic [8:0] COUNT9 = 9'(ENTRY_COUNT);

    // Request register.
    req_t        req_reg;
    logic [7:0]  idx_reg;
    logic [15:0] rsz_reg;

    // Descriptor tables.
    status_t     status_reg [ENTRY_COUNT];
    status_t     status_next [ENTRY_COUNT];
    logic [13:0] size_reg [ENTRY_COUNT];
    logic [13:0] size_next [ENTRY_COUNT];

    // Result register.
    err_t        err_reg;
    logic [7:0]  granted_reg;
    status_t     qst_reg;
    logic [13:0] qsz_reg;
    logic        can_alloc_reg;
    logic        wr_found_reg;
    logic [7:0]  wr_index_reg;

    err_t        err_next;
    logic [7:0]  granted_next;
    status_t     qst_next;
    logic [13:0] qsz_next;

    logic             in_range;
    logic [IDX_W-1:0] sel;
    status_t          sel_status;
    status_t          want_status;
    status_t          move_status;
    logic [13:0]      clamped_size;

    logic             free_cur_found;
    logic [IDX_W-1:0] free_cur_idx;
    logic             free_new_found;
    logic             wr_new_found;
    logic [7:0]       wr_new_idx;

    assign in_range     = ({1'b0, idx_reg} < COUNT9);
    assign sel          = idx_reg[IDX_W-1:0];
    assign sel_status   = status_reg[sel];
    assign clamped_size = (rsz_reg > SIZE_LIMIT) ? SIZE_LIMIT[13:0] : rsz_reg[13:0];

    // Expected prior status and new status of each forward transition.
    always_comb
    begin
        unique case (req_reg)
            REQ_MARK_WRITTEN:
            begin
                want_status = ST_BUSY;
                move_status = ST_WRITTEN;
            end
            REQ_MARK_XFERRED:
            begin
                want_status = ST_WRITTEN;
                move_status = ST_TRANSFERRED;
            end
            REQ_RELEASE:
            begin
                want_status = ST_TRANSFERRED;
                move_status = ST_FREE;
            end
            default:
            begin
                want_status = ST_FREE;
                move_status = ST_FREE;
            end
        endcase
    end

    // Lowest free entry before the request.
    always_comb
    begin
        free_cur_found = 1'b0;
        free_cur_idx   = '0;
        for (int k = ENTRY_COUNT - 1; k >= 0; k--)
        begin
            if (status_reg[k] == ST_FREE)
            begin
                free_cur_found = 1'b1;
                free_cur_idx   = IDX_W'(k);
            end
        end
    end

    // Apply the request to a copy of the tables.
    always_comb
    begin
        for (int k = 0; k < ENTRY_COUNT; k++)
        begin
            status_next[k] = status_reg[k];
            size_next[k]   = size_reg[k];
        end
        err_next     = ERR_OK;
        granted_next = '0;
        qst_next     = ST_FREE;
        qsz_next     = '0;

        unique case (req_reg)
            REQ_ALLOCATE:
            begin
                if (!free_cur_found)
                begin
                    err_next = ERR_NO_FREE;
                end
                else
                begin
                    status_next[free_cur_idx] = ST_BUSY;
                    size_next[free_cur_idx]   = clamped_size;
                    granted_next              = 8'(free_cur_idx);
                end
            end
            REQ_MARK_WRITTEN, REQ_MARK_XFERRED, REQ_RELEASE:
            begin
                priority if (!in_range)
                begin
                    err_next = ERR_BOUNDS;
                end
                else if (sel_status != want_status)
                begin
                    err_next = ERR_STATUS;
                end
                else
                begin
                    status_next[sel] = move_status;
                end
            end
            REQ_RESET_ALL:
            begin
                for (int k = 0; k < ENTRY_COUNT; k++)
                begin
                    status_next[k] = ST_FREE;
                end
            end
            REQ_QUERY:
            begin
                if (!in_range)
                begin
                    err_next = ERR_BOUNDS;
                end
                else
                begin
                    qst_next = sel_status;
                    qsz_next = size_reg[sel];
                end
            end
            default:
            begin
                err_next = ERR_OK;
            end
        endcase
    end

    // Summary flags taken from the tables as they stand after the request.
    always_comb
    begin
        free_new_found = 1'b0;
        wr_new_found   = 1'b0;
        wr_new_idx     = '0;
        for (int k = ENTRY_COUNT - 1; k >= 0; k--)
        begin
            if (status_next[k] == ST_FREE)
            begin
                free_new_found = 1'b1;
            end
            if (status_next[k] == ST_WRITTEN)
            begin
                wr_new_found = 1'b1;
                wr_new_idx   = 8'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_type;
            idx_reg <= entry_index;
            rsz_reg <= request_size;
        end
        if (cmd.commit)
        begin
            err_reg       <= err_next;
            granted_reg   <= granted_next;
            qst_reg       <= qst_next;
            qsz_reg       <= qsz_next;
            can_alloc_reg <= free_new_found;
            wr_found_reg  <= wr_new_found;
            wr_index_reg  <= wr_new_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ENTRY_COUNT; k++)
            begin
                status_reg[k] <= ST_FREE;
                size_reg[k]   <= '0;
            end
        end
        else if (cmd.commit)
        begin
            for (int k = 0; k < ENTRY_COUNT; k++)
            begin
                status_reg[k] <= status_next[k];
                size_reg[k]   <= size_next[k];
            end
        end
    end

    assign error_code    = err_reg;
    assign granted_index = granted_reg;
    assign entry_status  = qst_reg;
    assign entry_size    = qsz_reg;
    assign can_allocate  = can_alloc_reg;
    assign written_found = wr_found_reg;
    assign written_index = wr_index_reg;

    // Reset all leaves every entry free and none written.
    a_reset_all_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (req_reg == REQ_RESET_ALL) |=> can_allocate && !written_found)
        else $error("reset all left an entry in use");

    // The written index reads zero whenever no entry is written.
    a_written_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> written_found || (written_index == 8'd0))
        else $error("written index nonzero with no written entry");

    // A failed allocate grants nothing and reports a full pool.
    a_alloc_fail: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (req_reg == REQ_ALLOCATE)
            |=> (error_code == ERR_OK) || ((granted_index == 8'd0) && !can_allocate))
        else $error("failed allocate reported a grant or a free entry");

endmodule

`default_nettype wire
